// ----- hw/rtl/hsv2rgb_pkg.sv -----
// Package for the HSV to RGB converter: default widths, register indexes,
// reset values and sector codes. Depends on nothing; every other file uses it.
`default_nettype none

package hsv2rgb_pkg;

   localparam int DEF_HUE_BITS   = 16;
   localparam int DEF_COLOR_BITS = 8;

   // Configuration register map.
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SATURATION = 1'b0,
      CSR_BRIGHTNESS = 1'b1
   } csr_index_type;

   localparam int SATURATION_RESET = 204;
   localparam int BRIGHTNESS_RESET = 255;

   // Hue sectors, each one sixth of a turn.
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

`default_nettype wire

// ----- hw/rtl/hsv2rgb_if.sv -----
// Channel interfaces of the HSV to RGB converter: hue requests and RGB responses.
// Depends on hsv2rgb_pkg for the default widths.
`default_nettype none

interface hsv2rgb_req_if #(
   parameter int HUE_BITS = hsv2rgb_pkg::DEF_HUE_BITS
) ();
   logic                valid;
   logic                ready;
   logic [HUE_BITS-1:0] hue;

   modport source (output valid, output hue, input ready);
   modport sink   (input valid, input hue, output ready);
endinterface

interface hsv2rgb_rsp_if #(
   parameter int COLOR_BITS = hsv2rgb_pkg::DEF_COLOR_BITS
) ();
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hsv2rgb_csr.sv -----
// Saturation and brightness configuration registers of the HSV to RGB converter.
// Depends on hsv2rgb_pkg for the register map and reset values.
`default_nettype none

module hsv2rgb_csr #(
   parameter int COLOR_BITS = hsv2rgb_pkg::DEF_COLOR_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [hsv2rgb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COLOR_BITS-1:0]                 csr_write_data,
   output logic      [COLOR_BITS-1:0]                 saturation,
   output logic      [COLOR_BITS-1:0]                 brightness
);
   import hsv2rgb_pkg::*;

   logic [COLOR_BITS-1:0] saturation_ff, saturation_in;
   logic [COLOR_BITS-1:0] brightness_ff, brightness_in;

   always_comb begin
      saturation_in = saturation_ff;
      brightness_in = brightness_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SATURATION: saturation_in = csr_write_data;
            CSR_BRIGHTNESS: brightness_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saturation_ff <= COLOR_BITS'(SATURATION_RESET);
         brightness_ff <= COLOR_BITS'(BRIGHTNESS_RESET);
      end else begin
         saturation_ff <= saturation_in;
         brightness_ff <= brightness_in;
      end
   end

   assign saturation = saturation_ff;
   assign brightness = brightness_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_front.sv -----
// First two pipeline stages: the v*s product and hue*6, then chroma, sector and
// ramp fraction. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front #(
   parameter int HUE_BITS   = hsv2rgb_pkg::DEF_HUE_BITS,
   parameter int COLOR_BITS = hsv2rgb_pkg::DEF_COLOR_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [HUE_BITS-1:0]   in_hue,
   input  wire logic [COLOR_BITS-1:0] saturation,
   input  wire logic [COLOR_BITS-1:0] brightness,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [COLOR_BITS-1:0]      out_chroma,
   output logic [COLOR_BITS-1:0]      out_value,
   output hsv2rgb_pkg::sector_type    out_sector,
   output logic [HUE_BITS:0]          out_frac
);
   import hsv2rgb_pkg::*;

   localparam int PW = 2 * COLOR_BITS;
   localparam int HW = HUE_BITS + 3;

   // Stage 1.
   logic                  valid1_ff;
   logic [PW-1:0]         prod1_ff, prod1_in;
   logic [HW-1:0]         hue6_ff, hue6_in;
   logic [COLOR_BITS-1:0] value1_ff;
   logic                  ready1;

   // Stage 2.
   logic                  valid2_ff;
   logic [COLOR_BITS-1:0] chroma2_ff, chroma2_in;
   logic [COLOR_BITS-1:0] value2_ff;
   sector_type            sector2_ff, sector2_in;
   logic [HUE_BITS:0]     frac2_ff, frac2_in;
   logic                  ready2;

   logic [PW-1:0]         biased;
   logic [PW:0]           folded;
   logic [COLOR_BITS:0]   chroma_raw;
   logic [HUE_BITS-1:0]   f;

   assign ready2   = !valid2_ff || out_ready;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   assign prod1_in = PW'(saturation) * PW'(brightness);
   assign hue6_in  = (HW'(in_hue) << 2) + (HW'(in_hue) << 1);

   // Rounded v*s/CMAX: floor(u/(2^n-1)) is (u + 1 + (u >> n)) >> n while u stays
   // below 2^(2n)-1, with u the product plus half of CMAX rounded down.
   always_comb begin
      biased     = prod1_ff + PW'((1 << (COLOR_BITS - 1)) - 1);
      folded     = (PW + 1)'(biased) + (PW + 1)'(1) + (PW + 1)'(biased >> COLOR_BITS);
      chroma_raw = folded[PW:COLOR_BITS];
      if (chroma_raw > (COLOR_BITS + 1)'(value1_ff)) begin
         chroma2_in = value1_ff;
      end else begin
         chroma2_in = chroma_raw[COLOR_BITS-1:0];
      end
      sector2_in = sector_type'(hue6_ff[HW-1:HUE_BITS]);
      f          = hue6_ff[HUE_BITS-1:0];
      // Odd sectors ramp down, so their fraction counts from the far end.
      if (hue6_ff[HUE_BITS]) begin
         frac2_in = {1'b1, {HUE_BITS{1'b0}}} - {1'b0, f};
      end else begin
         frac2_in = {1'b0, f};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= in_valid;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         prod1_ff  <= prod1_in;
         hue6_ff   <= hue6_in;
         value1_ff <= brightness;
      end
      if (ready2 && valid1_ff) begin
         chroma2_ff <= chroma2_in;
         value2_ff  <= value1_ff;
         sector2_ff <= sector2_in;
         frac2_ff   <= frac2_in;
      end
   end

   assign out_valid  = valid2_ff;
   assign out_chroma = chroma2_ff;
   assign out_value  = value2_ff;
   assign out_sector = sector2_ff;
   assign out_frac   = frac2_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_back.sv -----
// Last two pipeline stages: the ramp product and offset, then rounding, the
// six-sector table and the output register. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_back #(
   parameter int HUE_BITS   = hsv2rgb_pkg::DEF_HUE_BITS,
   parameter int COLOR_BITS = hsv2rgb_pkg::DEF_COLOR_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [COLOR_BITS-1:0] in_chroma,
   input  wire logic [COLOR_BITS-1:0] in_value,
   input  wire hsv2rgb_pkg::sector_type in_sector,
   input  wire logic [HUE_BITS:0]     in_frac,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [COLOR_BITS-1:0]      out_red,
   output logic [COLOR_BITS-1:0]      out_green,
   output logic [COLOR_BITS-1:0]      out_blue
);
   import hsv2rgb_pkg::*;

   localparam int MW = COLOR_BITS + HUE_BITS + 1;

   // Stage 3.
   logic                  valid3_ff;
   logic [MW-1:0]         ramp3_ff, ramp3_in;
   logic [COLOR_BITS-1:0] chroma3_ff;
   logic [COLOR_BITS-1:0] offset3_ff, offset3_in;
   sector_type            sector3_ff;
   logic                  ready3;

   // Stage 4, the output register.
   logic                  valid4_ff;
   logic [COLOR_BITS-1:0] red4_ff, red4_in;
   logic [COLOR_BITS-1:0] green4_ff, green4_in;
   logic [COLOR_BITS-1:0] blue4_ff, blue4_in;
   logic                  ready4;

   logic [MW:0]           ramp_round;
   logic [COLOR_BITS+1:0] x_raw;
   logic [COLOR_BITS-1:0] x, c, r, g, b;

   assign ready4   = !valid4_ff || out_ready;
   assign ready3   = !valid3_ff || ready4;
   assign in_ready = ready3;

   assign ramp3_in   = MW'(in_chroma) * MW'(in_frac);
   assign offset3_in = in_value - in_chroma;

   always_comb begin
      ramp_round = (MW + 1)'(ramp3_ff) + (MW + 1)'(1 << (HUE_BITS - 1));
      x_raw      = ramp_round[MW:HUE_BITS];
      c          = chroma3_ff;
      if (x_raw > (COLOR_BITS + 2)'(c)) begin
         x = c;
      end else begin
         x = x_raw[COLOR_BITS-1:0];
      end
      case (sector3_ff)
         SECTOR_RED_YELLOW:   begin r = c; g = x; b = '0; end
         SECTOR_YELLOW_GREEN: begin r = x; g = c; b = '0; end
         SECTOR_GREEN_CYAN:   begin r = '0; g = c; b = x; end
         SECTOR_CYAN_BLUE:    begin r = '0; g = x; b = c; end
         SECTOR_BLUE_MAGENTA: begin r = x; g = '0; b = c; end
         default:             begin r = c; g = '0; b = x; end
      endcase
      red4_in   = r + offset3_ff;
      green4_in = g + offset3_ff;
      blue4_in  = b + offset3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready3) begin
            valid3_ff <= in_valid;
         end
         if (ready4) begin
            valid4_ff <= valid3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && in_valid) begin
         ramp3_ff   <= ramp3_in;
         chroma3_ff <= in_chroma;
         offset3_ff <= offset3_in;
         sector3_ff <= in_sector;
      end
      if (ready4 && valid3_ff) begin
         red4_ff   <= red4_in;
         green4_ff <= green4_in;
         blue4_ff  <= blue4_in;
      end
   end

   assign out_valid = valid4_ff;
   assign out_red   = red4_ff;
   assign out_green = green4_ff;
   assign out_blue  = blue4_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_converter_unit.sv -----
// Top level of the HSV to RGB converter: registers, front and back pipeline halves.
// Depends on hsv2rgb_pkg, hsv2rgb_if, hsv2rgb_csr, hsv2rgb_front and hsv2rgb_back.
//
//   Channel   Direction  Handshake               Carries
//   req_bus   in         valid/ready             hue
//   rsp_bus   out        valid/ready             red, green, blue
//   csr_*     in         csr_write_enable only   saturation (0), brightness (1)
//
// One transaction is accepted per clock unless a stalled response has backed up every
// stage to the input. Results pass the four register stages (product, chroma, ramp
// product, table). A stalled response holds each full stage with no empty stage
// after it; bubbles still fill, so nothing is lost or repeated. Synchronous reset
// empties the pipeline and loads saturation 204 and brightness 255.
`default_nettype none

module hsv_to_rgb_converter_unit #(
   parameter int HUE_BITS   = hsv2rgb_pkg::DEF_HUE_BITS,
   parameter int COLOR_BITS = hsv2rgb_pkg::DEF_COLOR_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   hsv2rgb_req_if.sink                                req_bus,
   hsv2rgb_rsp_if.source                              rsp_bus,
   input  wire logic                                  csr_write_enable,
   input  wire logic [hsv2rgb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COLOR_BITS-1:0]                 csr_write_data
);
   import hsv2rgb_pkg::*;

   logic [COLOR_BITS-1:0] saturation;
   logic [COLOR_BITS-1:0] brightness;

   logic                  mid_valid;
   logic                  mid_ready;
   logic [COLOR_BITS-1:0] mid_chroma;
   logic [COLOR_BITS-1:0] mid_value;
   sector_type            mid_sector;
   logic [HUE_BITS:0]     mid_frac;

   hsv2rgb_csr #(
      .COLOR_BITS (COLOR_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .saturation       (saturation),
      .brightness       (brightness)
   );

   hsv2rgb_front #(
      .HUE_BITS   (HUE_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_hue     (req_bus.hue),
      .saturation (saturation),
      .brightness (brightness),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_chroma (mid_chroma),
      .out_value  (mid_value),
      .out_sector (mid_sector),
      .out_frac   (mid_frac)
   );

   hsv2rgb_back #(
      .HUE_BITS   (HUE_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_chroma (mid_chroma),
      .in_value  (mid_value),
      .in_sector (mid_sector),
      .in_frac   (mid_frac),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_red   (rsp_bus.red),
      .out_green (rsp_bus.green),
      .out_blue  (rsp_bus.blue)
   );

endmodule

`default_nettype wire
